// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, checked only outside reset
`define SHA1HE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion, also checked while reset is applied
`define SHA1HE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/sha1he_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1he_pkg
// shared types and constants of the sha-1 hash engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha1he_pkg;

  localparam int unsigned NUM_WORDS  = 5;
  localparam int unsigned NUM_ROUNDS = 80;
  localparam int unsigned BLOCK_BITS = 512;

  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] FILL_LEN  = 6'd56;
  localparam logic [6:0] ROUND_LAST = 7'(NUM_ROUNDS - 1);
  localparam logic [2:0] WORD_LAST  = 3'(NUM_WORDS - 1);

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] H_INIT [NUM_WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [31:0] K_R0 = 32'h5a827999;
  localparam logic [31:0] K_R1 = 32'h6ed9eba1;
  localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
  localparam logic [31:0] K_R3 = 32'hca62c1d6;

  typedef enum logic [1:0] {
    SRC_MSG,
    SRC_PAD,
    SRC_ZERO,
    SRC_LEN
  } byte_src_e;

  typedef struct packed {
    logic      push;
    byte_src_e src;
    logic      load_work;
    logic      round;
    logic      add_chain;
    logic      out_adv;
    logic      reinit;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       round_last;
    logic       word_last;
  } dp_sts_t;

endpackage

// ===== src/sha1he_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha1he_ctrl
// sequencer for byte intake, padding, compression and digest output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1he_ctrl import sha1he_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  logic    byte_present_i,
  input  logic    end_of_message_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOAD,
    ST_ROUND,
    ST_CADD,
    ST_PAD80,
    ST_PADZ,
    ST_PADLEN,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  state_e ret_q, ret_d;

  always_comb begin
    cmd_o       = '0;
    cmd_o.src   = SRC_MSG;
    state_d     = state_q;
    ret_d       = ret_q;
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (byte_present_i) begin
            cmd_o.push = 1'b1;
            cmd_o.src  = SRC_MSG;
          end
          if (byte_present_i && (sts_i.fill == FILL_LAST)) begin
            state_d = ST_CLOAD;
            ret_d   = end_of_message_i ? ST_PAD80 : ST_IDLE;
          end else if (end_of_message_i) begin
            state_d = ST_PAD80;
          end
        end
      end
      ST_CLOAD: begin
        cmd_o.load_work = 1'b1;
        state_d         = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        if (sts_i.round_last) begin
          state_d = ST_CADD;
        end
      end
      ST_CADD: begin
        cmd_o.add_chain = 1'b1;
        state_d         = ret_q;
      end
      ST_PAD80: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = SRC_PAD;
        if (sts_i.fill == FILL_LAST) begin
          state_d = ST_CLOAD;
          ret_d   = ST_PADZ;
        end else begin
          state_d = ST_PADZ;
        end
      end
      ST_PADZ: begin
        if (sts_i.fill == FILL_LEN) begin
          state_d = ST_PADLEN;
        end else begin
          cmd_o.push = 1'b1;
          cmd_o.src  = SRC_ZERO;
          if (sts_i.fill == FILL_LAST) begin
            state_d = ST_CLOAD;
            ret_d   = ST_PADZ;
          end
        end
      end
      ST_PADLEN: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = SRC_LEN;
        if (sts_i.fill == FILL_LAST) begin
          state_d = ST_CLOAD;
          ret_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          cmd_o.out_adv = 1'b1;
          if (sts_i.word_last) begin
            cmd_o.reinit = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

endmodule

// ===== src/sha1he_dp.sv =====
// ----------------------------------------------------------------------------
// sha1he_dp
// block window, round unit, chaining words, byte count and digest select
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1he_dp import sha1he_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  input  logic [7:0]  data_byte_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_number_o,
  output logic        last_word_o
);

  // oldest schedule word sits in the top 32 bits
  logic [BLOCK_BITS-1:0] win_q, win_d;
  logic [31:0]  h_q [NUM_WORDS];
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [5:0]   fill_q;
  logic [6:0]   rnd_q;
  logic [60:0]  count_q;
  logic [2:0]   idx_q;

  logic [7:0]   push_byte;
  logic [63:0]  len_bits;
  logic [31:0]  w0, w2, w8, w13, w_new, w_mix;
  logic [31:0]  f_val, k_val, t_val;

  assign len_bits = {count_q, 3'b000};

  always_comb begin
    case (cmd_i.src)
      SRC_MSG:  push_byte = data_byte_i;
      SRC_PAD:  push_byte = PAD_BYTE;
      SRC_ZERO: push_byte = 8'h00;
      SRC_LEN:  push_byte = len_bits[8*(3'd7 - fill_q[2:0]) +: 8];
      default:  push_byte = 8'h00;
    endcase
  end

  assign w0    = win_q[511:480];
  assign w2    = win_q[447:416];
  assign w8    = win_q[255:224];
  assign w13   = win_q[95:64];
  assign w_mix = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    if (rnd_q < 7'd20) begin
      f_val = (b_q & c_q) ^ (~b_q & d_q);
      k_val = K_R0;
    end else if (rnd_q < 7'd40) begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K_R1;
    end else if (rnd_q < 7'd60) begin
      f_val = (b_q & c_q) ^ (b_q & d_q) ^ (c_q & d_q);
      k_val = K_R2;
    end else begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K_R3;
    end
  end

  assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w0;

  always_comb begin
    win_d = win_q;
    if (cmd_i.push) begin
      win_d = {win_q[BLOCK_BITS-9:0], push_byte};
    end else if (cmd_i.round) begin
      win_d = {win_q[BLOCK_BITS-33:0], w_new};
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (cmd_i.load_work) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end else if (cmd_i.round) begin
      a_q <= t_val;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      rnd_q   <= '0;
      count_q <= '0;
      idx_q   <= '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        h_q[i] <= H_INIT[i];
      end
    end else begin
      if (cmd_i.push) begin
        fill_q <= fill_q + 6'd1;
      end
      if (cmd_i.push && (cmd_i.src == SRC_MSG)) begin
        count_q <= count_q + 61'd1;
      end
      if (cmd_i.load_work) begin
        rnd_q <= '0;
      end else if (cmd_i.round) begin
        rnd_q <= rnd_q + 7'd1;
      end
      if (cmd_i.add_chain) begin
        h_q[0] <= h_q[0] + a_q;
        h_q[1] <= h_q[1] + b_q;
        h_q[2] <= h_q[2] + c_q;
        h_q[3] <= h_q[3] + d_q;
        h_q[4] <= h_q[4] + e_q;
      end
      if (cmd_i.reinit) begin
        count_q <= '0;
        idx_q   <= '0;
        for (int i = 0; i < NUM_WORDS; i++) begin
          h_q[i] <= H_INIT[i];
        end
      end else if (cmd_i.out_adv) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  assign sts_o.fill       = fill_q;
  assign sts_o.round_last = (rnd_q == ROUND_LAST);
  assign sts_o.word_last  = (idx_q == WORD_LAST);

  assign digest_word_o = h_q[idx_q];
  assign word_number_o = idx_q;
  assign last_word_o   = (idx_q == WORD_LAST);

endmodule

// ===== src/sha1_hash_engine_unit.sv =====
// ----------------------------------------------------------------------------
// sha1_hash_engine_unit
// sha-1 engine taking one message byte per item, digest out as five words
// ----------------------------------------------------------------------------
// A message byte is taken and shifted into the 512-bit block window. Every
// 64th byte starts a compression (load, 80 rounds through the single shared
// round unit, chaining add) during which in_stall_o is high. The end mark
// adds padding, one padding byte at a time with a turnaround state before the
// length bytes (9 to 72 bytes, with one or two compressions), then the five
// digest words come out one per cycle while out_stall_i is low. No new item
// is taken until the last digest word has been delivered.
`timescale 1ns / 1ps

module sha1_hash_engine_unit import sha1he_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_number_o,
  output logic        last_word_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sha1he_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .byte_present_i   (byte_present_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cmd_o            (cmd),
    .sts_i            (sts)
  );

  sha1he_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .data_byte_i   (data_byte_i),
    .digest_word_o (digest_word_o),
    .word_number_o (word_number_o),
    .last_word_o   (last_word_o)
  );

endmodule

// ===== src/sha1he_chk.sv =====
// ----------------------------------------------------------------------------
// sha1he_chk
// port-level checks of the sha-1 engine, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha1he_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_number_o,
  input logic        last_word_o
);

  // digest words go out while no item is taken
  `SHA1HE_ASSERT(a_out_blocks_in, out_valid_o |-> in_stall_o, "item taken during digest")

  // words leave in order
  `SHA1HE_ASSERT(a_word_order, (out_valid_o && !out_stall_i && !last_word_o) |=> (out_valid_o && (word_number_o == $past(word_number_o) + 3'd1)), "digest word out of order")

  // after the last word the engine is ready again
  `SHA1HE_ASSERT(a_ready_after, (out_valid_o && !out_stall_i && last_word_o) |=> (!out_valid_o && !in_stall_o), "not ready after digest")

  // held word stays put
  `SHA1HE_ASSERT(a_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(digest_word_o) && $stable(word_number_o)), "stalled word changed")

  // reset held over an edge leaves the engine idle
  `SHA1HE_ASSERT_ALWAYS(a_reset_idle, (!rst_ni ##1 !rst_ni) |-> (!out_valid_o && !in_stall_o), "not idle in reset")

endmodule

bind sha1_hash_engine_unit sha1he_chk u_sha1he_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .digest_word_o (digest_word_o),
  .word_number_o (word_number_o),
  .last_word_o   (last_word_o)
);
